### hw/rtl/lzssd_pkg.sv
// Package for the LZSS stream decoder: parse phases, byte kinds,
// controller/datapath command and status structs, fixed constants.
// No dependencies.
package lzssd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MIN_MATCH    = 3;
  localparam int unsigned MAX_RUN      = 18;
  localparam logic [15:0] FLAG_SENTINEL = 16'hFF00;

  // Parser phase once the header has been skipped
  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_LIT  = 2'd1,
    PH_REF1 = 2'd2,
    PH_REF2 = 2'd3
  } phase_t;

  // What the byte at the input means in the current parse position
  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,  // header, flag or first reference byte: no output
    KIND_LIT  = 2'd1,  // literal: one output byte
    KIND_REF2 = 2'd2   // second reference byte: a copy run
  } kind_t;

  typedef struct packed {
    logic take;   // accept the input byte and update the parser
    logic lit;    // emit the held literal
    logic rd;     // read the window at the copy source
    logic wr;     // emit and write back the copied byte
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;  // output register can take a byte this cycle
    logic  run_end;   // the copy byte in flight is the last of its run
  } dp_status_t;

endpackage

### hw/rtl/lzssd_if.sv
// Valid/ready stream interfaces for the LZSS decoder input and result channels.
// Depends on nothing.
interface lzssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

### hw/rtl/lzssd_datapath.sv
// LZSS decoder datapath: parser registers, 4096-byte window memory, copy
// pointers and the output register. Depends on lzssd_pkg.
module lzssd_datapath
  import lzssd_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       run_last,
  input  logic       out_ready
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned CW = $clog2(MAX_RUN + 1);
  localparam logic [AW-1:0] START_POS = AW'(WINDOW_SIZE - MAX_RUN);
  localparam logic [AW:0]   FILL_FULL = (AW+1)'(WINDOW_SIZE);

  logic [7:0] mem [WINDOW_SIZE];

  logic [2:0]    header_left_r, header_left_nxt;
  phase_t        phase_r, phase_nxt;
  logic [15:0]   flag_shift_r, flag_shift_nxt;
  logic [7:0]    pending_r, pending_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW:0]   fill_r, fill_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          run_last_r, run_last_nxt;
  logic [7:0]    rd_data_r;
  logic          rd_ok_r;

  logic          emit;
  logic [7:0]    emit_byte;
  logic          restart;
  logic [15:0]   flag_next;
  logic [AW-1:0] src_ofs;

  always_comb begin
    status.out_free = !out_valid_r || out_ready;
    status.run_end  = (cnt_r == CW'(1));
    if (header_left_r != 3'd0) begin
      status.kind = KIND_SKIP;
    end else begin
      unique case (phase_r)
        PH_LIT:  status.kind = KIND_LIT;
        PH_REF2: status.kind = KIND_REF2;
        default: status.kind = KIND_SKIP;
      endcase
    end
  end

  assign emit      = cmd.lit || cmd.wr;
  // Bytes never written in this stream read as zero
  assign emit_byte = cmd.lit ? byte_r : (rd_ok_r ? rd_data_r : 8'd0);
  assign flag_next = flag_shift_r >> 1;
  assign src_ofs   = src_r - START_POS;

  always_comb begin
    header_left_nxt = header_left_r;
    phase_nxt       = phase_r;
    flag_shift_nxt  = flag_shift_r;
    pending_nxt     = pending_r;
    wp_nxt          = wp_r;
    fill_nxt        = fill_r;
    src_nxt         = src_r;
    cnt_nxt         = cnt_r;
    byte_nxt        = byte_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r;
    out_byte_nxt    = out_byte_r;
    run_last_nxt    = run_last_r;
    restart         = 1'b0;

    if (cmd.take) begin
      byte_nxt = in_byte;
      last_nxt = in_last;
      if (status.kind == KIND_SKIP) begin
        if (header_left_r != 3'd0) begin
          header_left_nxt = header_left_r - 3'd1;
        end else if (phase_r == PH_FLAG) begin
          flag_shift_nxt = FLAG_SENTINEL | {8'd0, in_byte};
          phase_nxt      = in_byte[0] ? PH_LIT : PH_REF1;
        end else begin
          pending_nxt = in_byte;
          phase_nxt   = PH_REF2;
        end
        restart = in_last;
      end else if (status.kind == KIND_REF2) begin
        src_nxt = AW'({in_byte[7:4], pending_r});
        cnt_nxt = CW'(in_byte[3:0]) + CW'(MIN_MATCH);
      end
    end

    if (cmd.rd) begin
      src_nxt = src_r + AW'(1);
    end

    if (emit) begin
      wp_nxt = wp_r + AW'(1);
      if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + (AW+1)'(1);
      end
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      run_last_nxt  = cmd.lit || status.run_end;
      if (cmd.wr) begin
        cnt_nxt = cnt_r - CW'(1);
      end
      // Item finished: consume its flag bit
      if (cmd.lit || status.run_end) begin
        flag_shift_nxt = flag_next;
        if (!flag_next[8]) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = flag_next[0] ? PH_LIT : PH_REF1;
        end
        restart = last_r;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (restart) begin
      header_left_nxt = 3'(HEADER_BYTES);
      phase_nxt       = PH_FLAG;
      flag_shift_nxt  = 16'd0;
      pending_nxt     = 8'd0;
      wp_nxt          = START_POS;
      fill_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_left_r <= 3'(HEADER_BYTES);
      phase_r       <= PH_FLAG;
      flag_shift_r  <= 16'd0;
      pending_r     <= 8'd0;
      wp_r          <= START_POS;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      header_left_r <= header_left_nxt;
      phase_r       <= phase_nxt;
      flag_shift_r  <= flag_shift_nxt;
      pending_r     <= pending_nxt;
      wp_r          <= wp_nxt;
      fill_r        <= fill_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    cnt_r      <= cnt_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    run_last_r <= run_last_nxt;
  end

  // Window: one write and one registered read per cycle. The stream fills it
  // upward from the start position, so the fill count marks what is valid.
  always_ff @(posedge clk) begin
    if (emit) begin
      mem[wp_r] <= emit_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[src_r];
      rd_ok_r   <= ({1'b0, src_ofs} < fill_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign run_last  = run_last_r;

endmodule

### hw/rtl/lzssd_ctrl.sv
// LZSS decoder controller: accepts bytes and sequences literal emission and
// the read/write-back steps of a copy run. Depends on lzssd_pkg.
module lzssd_ctrl
  import lzssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIT  = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (status.kind)
            KIND_LIT:  state_nxt = S_LIT;
            KIND_REF2: state_nxt = S_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LIT: begin
        if (status.out_free) begin
          cmd.lit   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (status.out_free) begin
          cmd.wr    = 1'b1;
          state_nxt = status.run_end ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/lzss_stream_decoder.sv
// LZSS stream decoder top level: controller plus datapath with a 4096-byte window.
// Depends on lzssd_pkg, lzssd_if, lzssd_ctrl and lzssd_datapath.
//
//   channel  direction  payload             meaning
//   in_ch    sink       in_byte, in_last    compressed bytes, header included
//   out_ch   source     out_byte, run_last  decompressed bytes
//
// Steps: header, flag and first reference bytes are only accepted; a literal is
// accepted, then emitted; for a second reference byte each copied byte is one
// window read, then one write-back together with its emission.
// Reset: rst_n is synchronous, active low. The window holds no reset; a fill
// count since the start of the stream marks which entries read as zero, so no
// clearing pass is needed, at reset or between streams.
// Stalls: out_ch.ready low holds the output register and the controller;
// in_ch.ready is high only while the controller waits for a byte.
module lzss_stream_decoder
  import lzssd_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  lzssd_in_if.sink    in_ch,
  lzssd_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the transactions on both channels
  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Parse bytes, keep the window, drive the output register
  lzssd_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last),
    .out_ready (out_ch.ready)
  );

endmodule

### dv/lzss_stream_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for lzss_stream_decoder: sends compressed streams,
// predicts every decompressed byte and checks the result channel against it.
// Depends on lzssd_pkg, lzssd_if and the decoder RTL.
module lzss_stream_decoder_test
  import lzssd_pkg::*;
();

  localparam int unsigned WIN_BYTES   = 4096;
  localparam int unsigned START_PTR   = WIN_BYTES - MAX_RUN;
  localparam int          HALF_PERIOD = 6;
  localparam int          RESET_CYCLES = 6;
  localparam int          DRAIN_LIMIT = 20000;
  localparam int          DRAIN_TAIL  = 64;   // longer than one full 18-byte copy run
  localparam int          HOLD_OFF_CYCLES = 400;

  // How a generated stream ends
  typedef enum int {
    END_NORMAL,     // last flag on the final literal or second reference byte
    END_IN_HEADER,  // stream cut inside the header
    END_ON_FLAG,    // dangling flag byte carries the last flag
    END_ON_REF1     // lone first reference byte carries the last flag
  } stream_end_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  lzssd_in_if  in_ch ();
  lzssd_out_if out_ch ();

  lzss_stream_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Decoder state as the predictor sees it
  logic [7:0]  hist_buf [WIN_BYTES];
  logic [11:0] hist_ptr;
  logic [15:0] flag_reg;
  phase_t      phase_now;
  logic [7:0]  ref_lo;
  logic [2:0]  header_skip;

  // Decompressed bytes still owed by the block, oldest first
  out_beat_t pending_bytes [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;

  int errors          = 0;
  int bytes_accepted  = 0;
  int results_checked = 0;
  int streams_sent    = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return to the start-of-stream state: empty window, pointer just below the top.
  function automatic void restart_stream();
    foreach (hist_buf[i]) hist_buf[i] = 8'h00;
    hist_ptr    = 12'(START_PTR);
    flag_reg    = 16'h0000;
    phase_now   = PH_FLAG;
    ref_lo      = 8'h00;
    header_skip = 3'(HEADER_BYTES);
  endfunction

  function automatic void write_hist(input logic [7:0] v);
    hist_buf[hist_ptr] = v;
    hist_ptr = hist_ptr + 12'd1;
  endfunction

  // Drop the used flag bit; once the sentinel runs out, ask for a new flag byte.
  function automatic void next_item();
    flag_reg = flag_reg >> 1;
    if (!flag_reg[8]) phase_now = PH_FLAG;
    else phase_now = flag_reg[0] ? PH_LIT : PH_REF1;
  endfunction

  // Apply one accepted compressed byte and queue the bytes it decodes to.
  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    logic [11:0] src;
    int unsigned run_len;
    logic [7:0]  v;
    if (header_skip != 3'd0) begin
      header_skip = header_skip - 3'd1;
    end else begin
      case (phase_now)
        PH_FLAG: begin
          flag_reg  = FLAG_SENTINEL | {8'h00, b};
          phase_now = flag_reg[0] ? PH_LIT : PH_REF1;
        end
        PH_LIT: begin
          write_hist(b);
          pending_bytes.push_back(out_beat_t'{b, 1'b1});
          next_item();
        end
        PH_REF1: begin
          ref_lo    = b;
          phase_now = PH_REF2;
        end
        default: begin
          // Copy byte by byte so an overlapping run sees its own fresh output
          src     = {b[7:4], ref_lo};
          run_len = b[3:0] + MIN_MATCH;
          for (int unsigned i = 0; i < run_len; i++) begin
            v = hist_buf[src];
            write_hist(v);
            pending_bytes.push_back(out_beat_t'{v, 1'(i == run_len - 1)});
            src = src + 12'd1;
          end
          next_item();
        end
      endcase
    end
    if (is_last) restart_stream();
  endtask

  // ---------------------------------------------------------------------------
  // Input side: called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= is_last;
    // Hold the transaction until the block takes it
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b, is_last);
    bytes_accepted++;
    @(negedge clk);
  endtask

  // Build one stream on the fly: header, then flag groups of literals and references.
  task automatic send_stream(input int unsigned n_items, input int unsigned lit_pct,
                             input stream_end_t end_kind);
    int unsigned hdr_len;
    int unsigned count;
    logic [7:0]  flags;
    logic [11:0] src;
    logic [3:0]  len_code;
    logic        final_item;
    hdr_len = (end_kind == END_IN_HEADER) ? $urandom_range(HEADER_BYTES, 1) : HEADER_BYTES;
    for (int unsigned h = 0; h < hdr_len; h++)
      send_byte(8'($urandom), (end_kind == END_IN_HEADER) && (h == hdr_len - 1));
    if (end_kind != END_IN_HEADER) begin
      count = (end_kind == END_ON_FLAG) ? ((n_items + 7) / 8) * 8 : n_items;
      for (int unsigned k = 0; k < count; k++) begin
        final_item = (k == count - 1);
        if (k % 8 == 0) begin
          for (int j = 0; j < 8; j++) flags[j] = ($urandom_range(99) < lit_pct);
          // Force the closing item of a lone-reference stream to be a reference
          if (end_kind == END_ON_REF1 && k / 8 == (count - 1) / 8)
            flags[(count - 1) % 8] = 1'b0;
          send_byte(flags, 1'b0);
        end
        if (flags[k % 8]) begin
          send_byte(8'($urandom), final_item && end_kind == END_NORMAL);
        end else begin
          case ($urandom_range(3))
            0: src = 12'($urandom);                            // anywhere, often unwritten
            1: src = hist_ptr - 12'($urandom_range(48, 1));    // recent history
            2: src = hist_ptr - 12'd1;                         // overlapping run
            default: src = 12'hFFF - 12'($urandom_range(17));  // wraps past the top
          endcase
          len_code = 4'($urandom_range(15));
          send_byte(src[7:0], final_item && end_kind == END_ON_REF1);
          if (!(final_item && end_kind == END_ON_REF1))
            send_byte({src[11:8], len_code}, final_item && end_kind == END_NORMAL);
        end
      end
      if (end_kind == END_ON_FLAG) send_byte(8'($urandom), 1'b1);
    end
    streams_sent++;
  endtask

  // Mostly well-formed streams, with a share of broken endings.
  task automatic run_streams(input int n_bytes);
    int          stop_at;
    stream_end_t kind;
    stop_at = bytes_accepted + n_bytes;
    while (bytes_accepted < stop_at) begin
      case ($urandom_range(9))
        0:       kind = END_IN_HEADER;
        1:       kind = END_ON_FLAG;
        2:       kind = END_ON_REF1;
        default: kind = END_NORMAL;
      endcase
      send_stream($urandom_range(24, 1), $urandom_range(80, 20), kind);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Drive ready at the falling edge; a requested hold-off wins over random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready  <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest predicted byte.
  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result: expected none, got out_byte %02h run_last %0b",
                 $time, out_ch.out_byte, out_ch.run_last);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, got %02h",
                   $time, want.data, out_ch.out_byte);
          errors++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $display("%0t: run_last mismatch: expected %0b, got %0b",
                   $time, want.run_last, out_ch.run_last);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built streams: field extremes, overlap, wrap and every odd ending.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Header of extreme values, then flag 0x05: literal, ref, literal, five refs
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0); send_byte(8'hAA, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'hFF, 1'b0);                           // literal at the start position
    send_byte(8'hEE, 1'b0); send_byte(8'hF0, 1'b0);   // overlapping copy, length 3
    send_byte(8'h00, 1'b0);                           // literal zero
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);   // top of window, length 18, wraps
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);   // bottom of window, length 3
    send_byte(8'h00, 1'b0); send_byte(8'h0F, 1'b0);   // bottom, length 18
    send_byte(8'h80, 1'b0); send_byte(8'hF2, 1'b0);   // never-written entries read zero
    send_byte(8'hEE, 1'b0); send_byte(8'hFF, 1'b0);   // start position, length 18
    send_byte(8'hFF, 1'b1);                           // dangling flag byte ends it
    // Header cut after one byte
    send_byte(8'hFF, 1'b1);
    // Lone first reference byte at the end
    send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0); send_byte(8'h78, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_streams(50);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 87;
    recv_stall_pct = 0;
    run_streams(35);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    run_streams(35);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_streams(35);
  endtask

  // Hold ready low for a long stretch while reference-heavy streams keep coming.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF_CYCLES;
    send_stream(16, 20, END_NORMAL);
    send_stream(8, 50, END_NORMAL);
  endtask

  // Random bytes with random stream ends, then one last byte to realign.
  task automatic test_noise();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    for (int n = 0; n < 40; n++) send_byte(8'($urandom), $urandom_range(15) == 0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int drain_cycles;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    restart_stream();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_rate();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_noise();

    // Stop offering input and let the block drain at full rate
    in_ch.valid   <= 1'b0;
    recv_stall_pct = 0;
    drain_cycles   = 0;
    while (pending_bytes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_bytes.size());
      errors += pending_bytes.size();
    end

    $display("Ran %0d compressed bytes in %0d streams, checked %0d decoded bytes.",
             bytes_accepted, streams_sent, results_checked);
    $display("Covered idle and stall mixes, a long output hold-off and broken endings.");
    if (errors == 0) begin
      $display("lzss_stream_decoder_test passed");
    end else begin
      $display("lzss_stream_decoder_test failed");
    end
    $finish;
  end

  // Watchdog: end the run if it hangs
  initial begin
    #6_000_000;
    $display("lzss_stream_decoder_test failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/lzssd_pkg.sv
hw/rtl/lzssd_if.sv
hw/rtl/lzssd_datapath.sv
hw/rtl/lzssd_ctrl.sv
hw/rtl/lzss_stream_decoder.sv
dv/lzss_stream_decoder_test.sv
